FILE: design/ffpa_pkg.sv
// ffpa_pkg: shared types, constants and command/status structs for the
// first-fit pool allocator. Used by ffpa_ctrl, ffpa_dp and the top level.
`timescale 1ns / 1ps
package ffpa_pkg;

	localparam int MAX_SEGMENTS = 32;
	localparam int ADDR_WIDTH   = 32;

	localparam logic [32:0] GRAIN_MASK = 33'h0_0000_003F;
	localparam logic [32:0] ADDR_LIMIT = (ADDR_WIDTH >= 32) ? 33'h1_0000_0000 :
		(33'd1 << ADDR_WIDTH);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_SPACE  = 3'd1,
		ST_OUTSIDE   = 3'd2,
		ST_NOT_ALLOC = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic {
		CFG_POOL_BASE = 1'b0,
		CFG_POOL_SIZE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] request_size;
		logic [31:0] free_address;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] address;
		logic [31:0] remaining;
	} rsp_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
	} ent_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RD_FREE,
		OP_RD_USED,
		OP_INC_I,
		OP_ALLOC,
		OP_USED_MATCH,
		OP_POS_NEXT,
		OP_POS_PREV,
		OP_K_SET_J,
		OP_SU_RD,
		OP_SU_WR,
		OP_UC_DEC,
		OP_F_UPD,
		OP_SF_RD,
		OP_SF_WR,
		OP_FC_DEC,
		OP_SI_RD,
		OP_SI_WR,
		OP_INS
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    fin;
		status_t code;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  req_zero;
		logic  fc_zero;
		logic  uc_zero;
		logic  outside;
		logic  fit;
		logic  exact;
		logic  last_free;
		logic  last_used;
		logic  used_full;
		logic  free_full;
		logic  match;
		logic  after;
		logic  touch_prev;
		logic  touch_next;
		logic  su_more;
		logic  sf_more;
		logic  si_more;
	} sts_t;

endpackage

FILE: design/ffpa_dp.sv
// ffpa_dp: datapath of the pool allocator: free and used segment memories,
// counters, pool registers and result registers. Depends on ffpa_pkg.
`timescale 1ns / 1ps
module ffpa_dp #(
	parameter int MAX_SEGMENTS = ffpa_pkg::MAX_SEGMENTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  ffpa_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]        cfg_data,
	input  ffpa_pkg::req_t     req,
	input  ffpa_pkg::cmd_t     cmd,
	output ffpa_pkg::sts_t     sts,
	output ffpa_pkg::rsp_t     rsp
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	ffpa_pkg::ent_t free_mem [MAX_SEGMENTS];
	ffpa_pkg::ent_t used_mem [MAX_SEGMENTS];
	ffpa_pkg::ent_t free_rd_q, used_rd_q;
	ffpa_pkg::ent_t free_wd, used_wd;
	logic           free_we, used_we;
	logic [IW-1:0]  free_wa, used_wa, free_ra, used_ra;

	logic [31:0]       base_q, size_q, total_q, addr_q;
	logic [CW-1:0]     fc_q, uc_q, k_q, pos_q;
	logic [IW-1:0]     i_q, j_q;
	logic [32:0]       rounded_q;
	logic [31:0]       s_q, l_q;
	logic              nxt_v_q;
	ffpa_pkg::ent_t    prev_q, nxt_q;
	ffpa_pkg::req_t    req_q;
	ffpa_pkg::status_t status_q;

	logic [CW-1:0] k_inc, k_dec, i_inc_c, pos_dec;
	logic [31:0]   new_base, new_size, size_clip;
	logic [32:0]   room;
	logic [32:0]   rounded_in;

	assign k_inc   = k_q + CW'(1);
	assign k_dec   = k_q - CW'(1);
	assign i_inc_c = CW'(i_q) + CW'(1);
	assign pos_dec = pos_q - CW'(1);

	assign new_base = (cfg_index == ffpa_pkg::CFG_POOL_BASE) ? cfg_data : base_q;
	assign new_size = (cfg_index == ffpa_pkg::CFG_POOL_SIZE) ? cfg_data : size_q;
	assign room     = ffpa_pkg::ADDR_LIMIT - {1'b0, new_base};
	always_comb begin
		if ({1'b0, new_base} >= ffpa_pkg::ADDR_LIMIT) begin
			size_clip = '0;
		end else if ({1'b0, new_size} > room) begin
			size_clip = room[31:0];
		end else begin
			size_clip = new_size;
		end
	end

	assign rounded_in = ({1'b0, req.request_size} + ffpa_pkg::GRAIN_MASK) &
		~ffpa_pkg::GRAIN_MASK;

	// status toward the controller
	always_comb begin
		sts.kind       = req_q.kind;
		sts.req_zero   = (req_q.request_size == 32'd0);
		sts.fc_zero    = (fc_q == '0);
		sts.uc_zero    = (uc_q == '0);
		sts.outside    = (req_q.free_address < base_q) ||
			({1'b0, req_q.free_address} >= ({1'b0, base_q} + {1'b0, size_q}));
		sts.fit        = ({1'b0, free_rd_q.len} >= rounded_q);
		sts.exact      = ({1'b0, free_rd_q.len} == rounded_q);
		sts.last_free  = (i_inc_c == fc_q);
		sts.last_used  = (i_inc_c == uc_q);
		sts.used_full  = (uc_q == CW'(MAX_SEGMENTS));
		sts.free_full  = (fc_q == CW'(MAX_SEGMENTS));
		sts.match      = (used_rd_q.start == req_q.free_address);
		sts.after      = (free_rd_q.start > s_q);
		sts.touch_prev = (pos_q != '0) &&
			(({1'b0, prev_q.start} + {1'b0, prev_q.len}) == {1'b0, s_q});
		sts.touch_next = nxt_v_q && (({1'b0, s_q} + {1'b0, l_q}) == {1'b0, nxt_q.start});
		sts.su_more    = (k_inc < uc_q);
		sts.sf_more    = (k_inc < fc_q);
		sts.si_more    = (k_q > pos_q);
	end

	// memory port steering
	always_comb begin
		free_we = 1'b0;
		free_wa = i_q;
		free_wd = free_rd_q;
		used_we = 1'b0;
		used_wa = uc_q[IW-1:0];
		used_wd = used_rd_q;
		free_ra = i_q;
		used_ra = i_q;
		if (cfg_we) begin
			free_we = 1'b1;
			free_wa = '0;
			free_wd = '{start: new_base, len: size_clip};
		end else begin
			unique case (cmd.op)
				ffpa_pkg::OP_ALLOC: begin
					used_we = 1'b1;
					used_wd = '{start: free_rd_q.start, len: rounded_q[31:0]};
					free_we = !sts.exact;
					free_wd = '{start: free_rd_q.start + rounded_q[31:0],
						len: free_rd_q.len - rounded_q[31:0]};
				end
				ffpa_pkg::OP_SU_RD: used_ra = k_inc[IW-1:0];
				ffpa_pkg::OP_SU_WR: begin
					used_we = 1'b1;
					used_wa = k_q[IW-1:0];
				end
				ffpa_pkg::OP_F_UPD: begin
					if (sts.touch_prev) begin
						free_we = 1'b1;
						free_wa = pos_dec[IW-1:0];
						free_wd = '{start: prev_q.start,
							len: prev_q.len + l_q + (sts.touch_next ? nxt_q.len : 32'd0)};
					end else if (sts.touch_next) begin
						free_we = 1'b1;
						free_wa = pos_q[IW-1:0];
						free_wd = '{start: s_q, len: nxt_q.len + l_q};
					end
				end
				ffpa_pkg::OP_SF_RD: free_ra = k_inc[IW-1:0];
				ffpa_pkg::OP_SF_WR: begin
					free_we = 1'b1;
					free_wa = k_q[IW-1:0];
				end
				ffpa_pkg::OP_SI_RD: free_ra = k_dec[IW-1:0];
				ffpa_pkg::OP_SI_WR: begin
					free_we = 1'b1;
					free_wa = k_q[IW-1:0];
				end
				ffpa_pkg::OP_INS: begin
					free_we = 1'b1;
					free_wa = pos_q[IW-1:0];
					free_wd = '{start: s_q, len: l_q};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (free_we) free_mem[free_wa] <= free_wd;
		if (used_we) used_mem[used_wa] <= used_wd;
		free_rd_q <= free_mem[free_ra];
		used_rd_q <= used_mem[used_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			size_q  <= '0;
			total_q <= '0;
			fc_q    <= '0;
			uc_q    <= '0;
		end else if (cfg_we) begin
			base_q  <= new_base;
			size_q  <= new_size;
			total_q <= size_clip;
			fc_q    <= (size_clip != 32'd0) ? CW'(1) : '0;
			uc_q    <= '0;
		end else begin
			unique case (cmd.op)
				ffpa_pkg::OP_ALLOC: begin
					uc_q    <= uc_q + CW'(1);
					total_q <= total_q - rounded_q[31:0];
				end
				ffpa_pkg::OP_UC_DEC: uc_q <= uc_q - CW'(1);
				ffpa_pkg::OP_F_UPD: total_q <= total_q + l_q;
				ffpa_pkg::OP_FC_DEC: fc_q <= fc_q - CW'(1);
				ffpa_pkg::OP_INS: fc_q <= fc_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) status_q <= cmd.code;
		unique case (cmd.op)
			ffpa_pkg::OP_LOAD: begin
				req_q     <= req;
				rounded_q <= rounded_in;
				i_q       <= '0;
				addr_q    <= '0;
			end
			ffpa_pkg::OP_INC_I: i_q <= i_q + IW'(1);
			ffpa_pkg::OP_ALLOC: begin
				addr_q <= free_rd_q.start;
				k_q    <= CW'(i_q);
			end
			ffpa_pkg::OP_USED_MATCH: begin
				s_q     <= used_rd_q.start;
				l_q     <= used_rd_q.len;
				j_q     <= i_q;
				i_q     <= '0;
				pos_q   <= '0;
				nxt_v_q <= 1'b0;
			end
			ffpa_pkg::OP_POS_NEXT: begin
				nxt_q   <= free_rd_q;
				nxt_v_q <= 1'b1;
				pos_q   <= CW'(i_q);
			end
			ffpa_pkg::OP_POS_PREV: begin
				prev_q <= free_rd_q;
				pos_q  <= i_inc_c;
				i_q    <= i_q + IW'(1);
			end
			ffpa_pkg::OP_K_SET_J: k_q <= CW'(j_q);
			ffpa_pkg::OP_SU_WR: k_q <= k_inc;
			ffpa_pkg::OP_F_UPD: k_q <= sts.touch_prev ? pos_q : fc_q;
			ffpa_pkg::OP_SF_WR: k_q <= k_inc;
			ffpa_pkg::OP_SI_WR: k_q <= k_dec;
			default: ;
		endcase
	end

	assign rsp.status    = status_q;
	assign rsp.address   = addr_q;
	assign rsp.remaining = total_q;

endmodule

FILE: design/ffpa_ctrl.sv
// ffpa_ctrl: sequencing state machine of the pool allocator; drives
// datapath commands from datapath status. Depends on ffpa_pkg.
`timescale 1ns / 1ps
module ffpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ffpa_pkg::sts_t sts,
	output ffpa_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_CHK    = 18'h00002,
		S_A_RD   = 18'h00004,
		S_A_CMP  = 18'h00008,
		S_A_TAKE = 18'h00010,
		S_U_RD   = 18'h00020,
		S_U_CMP  = 18'h00040,
		S_FR_RD  = 18'h00080,
		S_FR_CMP = 18'h00100,
		S_F_CHK  = 18'h00200,
		S_SU_RD  = 18'h00400,
		S_SU_WR  = 18'h00800,
		S_F_UPD  = 18'h01000,
		S_SF_RD  = 18'h02000,
		S_SF_WR  = 18'h04000,
		S_SI_RD  = 18'h08000,
		S_SI_WR  = 18'h10000,
		S_DONE   = 18'h20000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '{op: ffpa_pkg::OP_NONE, fin: 1'b0, code: ffpa_pkg::ST_OK};
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = ffpa_pkg::OP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.kind == ffpa_pkg::KIND_ALLOC) begin
					if (sts.req_zero || sts.fc_zero) begin
						cmd.fin  = 1'b1;
						cmd.code = ffpa_pkg::ST_NO_SPACE;
						state_d  = S_DONE;
					end else begin
						state_d = S_A_RD;
					end
				end else if (sts.outside) begin
					cmd.fin  = 1'b1;
					cmd.code = ffpa_pkg::ST_OUTSIDE;
					state_d  = S_DONE;
				end else if (sts.uc_zero) begin
					cmd.fin  = 1'b1;
					cmd.code = ffpa_pkg::ST_NOT_ALLOC;
					state_d  = S_DONE;
				end else begin
					state_d = S_U_RD;
				end
			end
			S_A_RD: begin
				cmd.op  = ffpa_pkg::OP_RD_FREE;
				state_d = S_A_CMP;
			end
			S_A_CMP: begin
				if (sts.fit) begin
					state_d = S_A_TAKE;
				end else if (sts.last_free) begin
					cmd.fin  = 1'b1;
					cmd.code = ffpa_pkg::ST_NO_SPACE;
					state_d  = S_DONE;
				end else begin
					cmd.op  = ffpa_pkg::OP_INC_I;
					state_d = S_A_RD;
				end
			end
			S_A_TAKE: begin
				if (sts.used_full) begin
					cmd.fin  = 1'b1;
					cmd.code = ffpa_pkg::ST_FULL;
					state_d  = S_DONE;
				end else begin
					cmd.op = ffpa_pkg::OP_ALLOC;
					if (sts.exact) begin
						state_d = S_SF_RD;
					end else begin
						cmd.fin = 1'b1;
						state_d = S_DONE;
					end
				end
			end
			S_U_RD: begin
				cmd.op  = ffpa_pkg::OP_RD_USED;
				state_d = S_U_CMP;
			end
			S_U_CMP: begin
				if (sts.match) begin
					cmd.op  = ffpa_pkg::OP_USED_MATCH;
					state_d = sts.fc_zero ? S_F_CHK : S_FR_RD;
				end else if (sts.last_used) begin
					cmd.fin  = 1'b1;
					cmd.code = ffpa_pkg::ST_NOT_ALLOC;
					state_d  = S_DONE;
				end else begin
					cmd.op  = ffpa_pkg::OP_INC_I;
					state_d = S_U_RD;
				end
			end
			S_FR_RD: begin
				cmd.op  = ffpa_pkg::OP_RD_FREE;
				state_d = S_FR_CMP;
			end
			S_FR_CMP: begin
				if (sts.after) begin
					cmd.op  = ffpa_pkg::OP_POS_NEXT;
					state_d = S_F_CHK;
				end else begin
					cmd.op  = ffpa_pkg::OP_POS_PREV;
					state_d = sts.last_free ? S_F_CHK : S_FR_RD;
				end
			end
			S_F_CHK: begin
				if (!sts.touch_prev && !sts.touch_next && sts.free_full) begin
					cmd.fin  = 1'b1;
					cmd.code = ffpa_pkg::ST_FULL;
					state_d  = S_DONE;
				end else begin
					cmd.op  = ffpa_pkg::OP_K_SET_J;
					state_d = S_SU_RD;
				end
			end
			S_SU_RD: begin
				if (sts.su_more) begin
					cmd.op  = ffpa_pkg::OP_SU_RD;
					state_d = S_SU_WR;
				end else begin
					cmd.op  = ffpa_pkg::OP_UC_DEC;
					state_d = S_F_UPD;
				end
			end
			S_SU_WR: begin
				cmd.op  = ffpa_pkg::OP_SU_WR;
				state_d = S_SU_RD;
			end
			S_F_UPD: begin
				cmd.op = ffpa_pkg::OP_F_UPD;
				if (sts.touch_prev && sts.touch_next) begin
					state_d = S_SF_RD;
				end else if (sts.touch_prev || sts.touch_next) begin
					cmd.fin = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_SI_RD;
				end
			end
			S_SF_RD: begin
				if (sts.sf_more) begin
					cmd.op  = ffpa_pkg::OP_SF_RD;
					state_d = S_SF_WR;
				end else begin
					cmd.op  = ffpa_pkg::OP_FC_DEC;
					cmd.fin = 1'b1;
					state_d = S_DONE;
				end
			end
			S_SF_WR: begin
				cmd.op  = ffpa_pkg::OP_SF_WR;
				state_d = S_SF_RD;
			end
			S_SI_RD: begin
				if (sts.si_more) begin
					cmd.op  = ffpa_pkg::OP_SI_RD;
					state_d = S_SI_WR;
				end else begin
					cmd.op  = ffpa_pkg::OP_INS;
					cmd.fin = 1'b1;
					state_d = S_DONE;
				end
			end
			S_SI_WR: begin
				cmd.op  = ffpa_pkg::OP_SI_WR;
				state_d = S_SI_RD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

FILE: design/first_fit_pool_allocator.sv
// first_fit_pool_allocator: top level; joins the controller and datapath.
// Depends on ffpa_pkg, ffpa_ctrl and ffpa_dp.
//
// Usage: a request transaction is taken when start is high and busy is low;
// req carries kind (allocate or free), request_size and free_address.
// Each request gives one result on rsp, marked by done for exactly one cycle;
// the receiver cannot stall it. busy stays high from acceptance through the
// done cycle, so one request is handled at a time; the next one is taken no
// earlier than the cycle after done.
// Steps from acceptance to done:
//   allocate: scan the free segments for the first that fits, then shift the
//             free entries down when a segment is used up exactly.
//   free:     scan the allocated blocks for a match, scan the free segments
//             for its place, shift the allocated entries down, then shift the
//             free entries when the block merges both ways or is inserted.
// Each segment memory has one registered read port, so each visited entry
// costs a read and a compare or write.
// Configuration: cfg_we writes pool_base (index 0) or pool_size (index 1) at
// once; either write empties the allocated list and rebuilds the free list.
// Write only while busy is low. Reset gives an empty pool at address 0.
`timescale 1ns / 1ps
module first_fit_pool_allocator #(
	parameter int MAX_SEGMENTS = ffpa_pkg::MAX_SEGMENTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ffpa_pkg::req_t     req,
	output logic               done,
	output ffpa_pkg::rsp_t     rsp,
	input  logic               cfg_we,
	input  ffpa_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]        cfg_data
);

	ffpa_pkg::cmd_t cmd;
	ffpa_pkg::sts_t sts;

	ffpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ffpa_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction did not raise busy");

	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != ffpa_pkg::ST_OK) |-> (rsp.address == 32'd0))
		else $error("failed transaction returned a nonzero address");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a transaction in flight");
`endif

endmodule
